@@ hw/rtl/gwb_pkg.sv @@
// ----------------------------------------------------------------------------
// gwb_pkg: shared types and constants of the greedy word wrap line breaker
// item formats, character codes, classes and default settings
// ----------------------------------------------------------------------------
package gwb_pkg;

    // character codes with a meaning of their own
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_HYPHEN  = 8'd45;

    // defaults
    localparam logic [11:0] RESET_MAX_LINE_WIDTH = 12'd640;
    localparam int          DEF_MAX_LINE_CHARS   = 1023;
    localparam int          DEF_TAB_EXTRA        = 20;
    localparam int          CMD_QUEUE_DEPTH      = 4;
    localparam int          RES_QUEUE_DEPTH      = 4;

    // input item
    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] glyph_px;
        logic [7:0] glyph_advance;
        logic       glyph_found;
        logic       last_char;
    } t_char_item;

    // result item
    typedef struct packed {
        logic [9:0]  line_chars;
        logic [11:0] line_px;
        logic        string_done;
        logic        wrap_error;
        logic        last_of_run;
    } t_line_result;

    // character class seen by the engine
    typedef enum logic [1:0] {
        CC_OTHER,
        CC_SPACE,
        CC_HYPHEN,
        CC_NEWLINE
    } t_char_class;

    // classified item between front and engine
    typedef struct packed {
        t_char_class cls;
        logic        found;
        logic        last;
        logic [8:0]  dx;
        logic [8:0]  test_w;
    } t_cmd;

    // state of the open line
    typedef struct packed {
        logic [11:0] run_w;
        logic [9:0]  run_c;
        logic [11:0] brk_w;
        logic [9:0]  brk_c;
        logic [11:0] tail_w;
        logic [9:0]  tail_c;
        logic        brk_seen;
    } t_line_state;

endpackage

@@ hw/rtl/gwb_fifo.sv @@
// ----------------------------------------------------------------------------
// gwb_fifo: small register queue
// takes up to two items per cycle, hands out one per cycle
// ----------------------------------------------------------------------------
module gwb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_wr_cnt,
    input  logic [W-1:0] i_wr_data0,
    input  logic [W-1:0] i_wr_data1,
    input  logic         i_rd_en,
    output logic [W-1:0] o_rd_data,
    output logic         o_empty,
    output logic         o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_free
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] wptr1;

    assign wptr1 = r_wptr + AW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = r_wptr + AW'(i_wr_cnt);
        n_rptr  = r_rptr + AW'(i_rd_en);
        n_count = r_count + CW'(i_wr_cnt) - CW'(i_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_wr_data0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[wptr1] <= i_wr_data1;
        end
    end

    assign o_rd_data = r_mem[r_rptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_free    = CW'(DEPTH) - r_count;

endmodule

@@ hw/rtl/gwb_front.sv @@
// ----------------------------------------------------------------------------
// gwb_front: character classifier
// sorts each item into its break class and works out its advance
// ----------------------------------------------------------------------------
module gwb_front #(
    parameter int TAB_EXTRA = gwb_pkg::DEF_TAB_EXTRA
) (
    input  gwb_pkg::t_char_item i_item,
    output gwb_pkg::t_cmd       o_cmd
);
    import gwb_pkg::*;

    logic [8:0] dx;

    // advance with the tab extra
    assign dx = {1'b0, i_item.glyph_advance} +
                ((i_item.char_code == CHAR_TAB) ? 9'(TAB_EXTRA) : 9'd0);

    // class of the character, and the width tested against the limit
    always_comb begin
        o_cmd.dx     = dx;
        o_cmd.test_w = i_item.last_char ? {1'b0, i_item.glyph_px} : dx;
        o_cmd.found  = i_item.glyph_found;
        o_cmd.last   = i_item.last_char;
        unique case (i_item.char_code)
            CHAR_NEWLINE: o_cmd.cls = CC_NEWLINE;
            CHAR_SPACE:   o_cmd.cls = CC_SPACE;
            CHAR_HYPHEN:  o_cmd.cls = CC_HYPHEN;
            default:      o_cmd.cls = CC_OTHER;
        endcase
    end

endmodule

@@ hw/rtl/gwb_engine.sv @@
// ----------------------------------------------------------------------------
// gwb_engine: line breaking engine
// runs the greedy fit on one classified item a cycle while the result queue has room, emits up to two lines
// ----------------------------------------------------------------------------
module gwb_engine #(
    parameter int MAX_LINE_CHARS = gwb_pkg::DEF_MAX_LINE_CHARS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [11:0]          i_max_width,
    input  gwb_pkg::t_cmd        i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  logic                 i_room,
    output logic [1:0]           o_res_cnt,
    output gwb_pkg::t_line_result o_res0,
    output gwb_pkg::t_line_result o_res1
);
    import gwb_pkg::*;

    localparam logic [9:0] CHAR_CAP =
        (MAX_LINE_CHARS < 1023) ? 10'(MAX_LINE_CHARS) : 10'd1023;

    t_line_state r_line, n_line;
    logic        r_skip, n_skip;

    t_line_state wrapped, fit_cur, fit_wr;
    logic [12:0] sum_cur, sum_wr;
    logic        ov0, ov1, fire;
    t_line_result res0, res1;
    logic [1:0]  cnt;

    function automatic logic [11:0] sat12(logic [12:0] v);
        return v[12] ? 12'hFFF : v[11:0];
    endfunction

    function automatic logic [9:0] inc_chars(logic [9:0] c);
        return (c < CHAR_CAP) ? c + 10'd1 : CHAR_CAP;
    endfunction

    function automatic t_line_result mk_res(logic [9:0] c, logic [11:0] w,
                                            logic done, logic err);
        t_line_result r;
        r.line_chars  = c;
        r.line_px     = w;
        r.string_done = done;
        r.wrap_error  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // line state after a character that fits
    function automatic t_line_state fit_char(t_line_state b, t_cmd c);
        t_line_state f;
        logic [12:0] s;
        logic [12:0] ts;
        f     = b;
        s     = {1'b0, b.run_w} + {4'd0, c.dx};
        ts    = {1'b0, b.tail_w} + {4'd0, c.dx};
        f.run_w = sat12(s);
        f.run_c = inc_chars(b.run_c);
        unique case (c.cls)
            CC_SPACE: begin
                f.brk_w    = b.run_w;
                f.brk_c    = b.run_c;
                f.brk_seen = 1'b1;
                f.tail_w   = '0;
                f.tail_c   = '0;
            end
            CC_HYPHEN: begin
                f.brk_w    = sat12(s);
                f.brk_c    = b.run_c;
                f.brk_seen = 1'b1;
                f.tail_w   = '0;
                f.tail_c   = '0;
            end
            default: begin
                f.tail_w = sat12(ts);
                f.tail_c = inc_chars(b.tail_c);
            end
        endcase
        return f;
    endfunction

    assign fire      = i_cmd_valid && i_room;
    assign o_cmd_pop = fire;

    // line after a wrap at the last candidate
    always_comb begin
        wrapped        = '0;
        wrapped.run_w  = r_line.tail_w;
        wrapped.run_c  = r_line.tail_c;
    end

    // overflow tests for the open line and for the wrapped line
    assign sum_cur = {1'b0, r_line.run_w} + {4'd0, i_cmd.test_w};
    assign sum_wr  = {1'b0, r_line.tail_w} + {4'd0, i_cmd.test_w};
    assign ov0     = sum_cur > {1'b0, i_max_width};
    assign ov1     = sum_wr > {1'b0, i_max_width};

    assign fit_cur = fit_char(r_line, i_cmd);
    assign fit_wr  = fit_char(wrapped, i_cmd);

    // decision per item
    always_comb begin
        n_line = r_line;
        n_skip = r_skip;
        res0   = '0;
        res1   = '0;
        cnt    = 2'd0;
        if (fire) begin
            if (r_skip) begin
                if (i_cmd.last) begin
                    n_skip = 1'b0;
                end
            end else if (i_cmd.cls == CC_NEWLINE) begin
                res0   = mk_res(r_line.run_c, r_line.run_w, 1'b0, 1'b0);
                res1   = mk_res('0, '0, 1'b1, 1'b0);
                n_line = '0;
                cnt    = i_cmd.last ? 2'd2 : 2'd1;
            end else if (!i_cmd.found) begin
                res0   = mk_res('0, '0, i_cmd.last, 1'b1);
                n_line = '0;
                n_skip = !i_cmd.last;
                cnt    = 2'd1;
            end else if (ov0 && i_cmd.cls == CC_SPACE) begin
                res0   = mk_res(r_line.run_c, r_line.run_w, 1'b0, 1'b0);
                res1   = mk_res('0, '0, 1'b1, 1'b0);
                n_line = '0;
                cnt    = i_cmd.last ? 2'd2 : 2'd1;
            end else if (ov0 && r_line.brk_seen) begin
                res0 = mk_res(r_line.brk_c, r_line.brk_w, 1'b0, 1'b0);
                if (ov1) begin
                    res1   = mk_res('0, '0, i_cmd.last, 1'b1);
                    n_line = '0;
                    n_skip = !i_cmd.last;
                    cnt    = 2'd2;
                end else if (i_cmd.last) begin
                    res1   = mk_res(fit_wr.run_c, fit_wr.run_w, 1'b1, 1'b0);
                    n_line = '0;
                    cnt    = 2'd2;
                end else begin
                    n_line = fit_wr;
                    cnt    = 2'd1;
                end
            end else if (ov0) begin
                res0   = mk_res('0, '0, i_cmd.last, 1'b1);
                n_line = '0;
                n_skip = !i_cmd.last;
                cnt    = 2'd1;
            end else if (i_cmd.last) begin
                res0   = mk_res(fit_cur.run_c, fit_cur.run_w, 1'b1, 1'b0);
                n_line = '0;
                cnt    = 2'd1;
            end else begin
                n_line = fit_cur;
            end
        end
    end

    // mark the final line of each item
    always_comb begin
        o_res0 = res0;
        o_res1 = res1;
        o_res0.last_of_run = (cnt == 2'd1);
        o_res1.last_of_run = (cnt == 2'd2);
        o_res_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_skip <= 1'b0;
        end else begin
            r_line <= n_line;
            r_skip <= n_skip;
        end
    end

endmodule

@@ hw/rtl/greedy_word_wrap_line_breaker.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker: greedy word wrap top level
// a line reaches the result side through the command queue, the engine and the result queue
// throughput: 1 item per cycle; the engine fires when the result queue has
//   room for 2 lines, so the pop rate sets the pace for items that end lines
// reset: line state and error skip cleared, width limit 640, queues empty
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker #(
    parameter int MAX_LINE_CHARS = gwb_pkg::DEF_MAX_LINE_CHARS,
    parameter int TAB_EXTRA      = gwb_pkg::DEF_TAB_EXTRA
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  gwb_pkg::t_char_item   i_char,
    output logic                  empty,
    input  logic                  pop,
    output gwb_pkg::t_line_result o_line,
    input  logic                  i_cfg_we,
    input  logic [11:0]           i_cfg_wdata
);
    import gwb_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_line_result);
    localparam int RFW   = $clog2(RES_QUEUE_DEPTH + 1);

    logic [11:0]  r_max_width;
    t_cmd         front_cmd, eng_cmd;
    logic [CMD_W-1:0] cmd_rd;
    logic         cmd_empty, cmd_pop;
    logic [RFW-1:0] res_free;
    logic [1:0]   res_cnt;
    t_line_result res0, res1;
    logic [RES_W-1:0] res_rd;
    logic         room;

    // width limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= RESET_MAX_LINE_WIDTH;
        end else if (i_cfg_we) begin
            r_max_width <= i_cfg_wdata;
        end
    end

    // front: classify incoming items
    gwb_front #(.TAB_EXTRA(TAB_EXTRA)) u_front (
        .i_item (i_char),
        .o_cmd  (front_cmd)
    );

    // queue between front and engine
    gwb_fifo #(.W(CMD_W), .DEPTH(CMD_QUEUE_DEPTH)) u_cmd_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   ({1'b0, push && !full}),
        .i_wr_data0 (front_cmd),
        .i_wr_data1 (front_cmd),
        .i_rd_en    (cmd_pop),
        .o_rd_data  (cmd_rd),
        .o_empty    (cmd_empty),
        .o_full     (full),
        .o_free     ()
    );

    assign eng_cmd = t_cmd'(cmd_rd);
    assign room    = (res_free >= RFW'(2));

    // engine: greedy fit
    gwb_engine #(.MAX_LINE_CHARS(MAX_LINE_CHARS)) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_width      (r_max_width),
        .i_cmd            (eng_cmd),
        .i_cmd_valid      (!cmd_empty),
        .o_cmd_pop        (cmd_pop),
        .i_room           (room),
        .o_res_cnt        (res_cnt),
        .o_res0           (res0),
        .o_res1           (res1)
    );

    // result queue
    gwb_fifo #(.W(RES_W), .DEPTH(RES_QUEUE_DEPTH)) u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   (res_cnt),
        .i_wr_data0 (res0),
        .i_wr_data1 (res1),
        .i_rd_en    (pop && !empty),
        .o_rd_data  (res_rd),
        .o_empty    (empty),
        .o_full     (),
        .o_free     (res_free)
    );

    assign o_line = t_line_result'(res_rd);

endmodule

@@ bench/gwb_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwb_line_checker: scoreboard for the greedy word wrap line breaker
// watches the character and line channels and the width register, predicts
// the lines of every accepted item and compares each popped line with the
// oldest prediction, field by field
// ----------------------------------------------------------------------------
module gwb_line_checker #(
    parameter int MAX_LINE_CHARS = gwb_pkg::DEF_MAX_LINE_CHARS,
    parameter int TAB_EXTRA      = gwb_pkg::DEF_TAB_EXTRA
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  gwb_pkg::t_char_item   i_char,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  gwb_pkg::t_line_result i_line,
    input  logic                  i_cfg_we,
    input  logic [11:0]           i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_lines_pending,
    output int                    o_lines_seen,
    output int                    o_error_lines
);
    import gwb_pkg::*;

    localparam int unsigned CHAR_CAP = (MAX_LINE_CHARS < 1023) ? MAX_LINE_CHARS : 1023;
    localparam int unsigned WIDTH_CAP = 4095;

    // predicted line state and width limit
    int unsigned limit_w;
    int unsigned line_w, line_c;
    int unsigned brk_w, brk_c;
    int unsigned tail_w, tail_c;
    bit          have_break;
    bit          skip_rest;

    // lines still owed by the block, oldest first
    t_line_result expected_lines[$];
    t_line_result staged;
    bit           staged_valid;

    initial begin
        o_mismatches    = 0;
        o_lines_pending = 0;
        o_lines_seen    = 0;
        o_error_lines   = 0;
        staged_valid    = 1'b0;
    end

    function automatic int unsigned bump_count(input int unsigned n);
        return (n < CHAR_CAP) ? n + 1 : CHAR_CAP;
    endfunction

    function automatic t_line_result line_rec(input int unsigned chars, input int unsigned width,
                                              input bit done, input bit err);
        t_line_result r;
        r.line_chars  = 10'((chars > CHAR_CAP) ? CHAR_CAP : chars);
        r.line_px     = 12'((width > WIDTH_CAP) ? WIDTH_CAP : width);
        r.string_done = done;
        r.wrap_error  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_open_line();
        line_w     = 0;
        line_c     = 0;
        brk_w      = 0;
        brk_c      = 0;
        tail_w     = 0;
        tail_c     = 0;
        have_break = 1'b0;
    endtask

    // hold back one line so the final line of an item can be flagged
    task automatic add_line(input int unsigned chars, input int unsigned width,
                            input bit done, input bit err);
        if (staged_valid) begin
            expected_lines.push_back(staged);
        end
        staged       = line_rec(chars, width, done, err);
        staged_valid = 1'b1;
    endtask

    // lines finished by one character
    task automatic predict_lines(input t_char_item c);
        int unsigned dx;
        int unsigned tw;
        bit          again;
        bit          retried;
        if (skip_rest) begin
            // dropping characters after an error up to the string end
            if (c.last_char) begin
                skip_rest = 1'b0;
            end
        end else if (c.char_code == CHAR_NEWLINE) begin
            add_line(line_c, line_w, 1'b0, 1'b0);
            clear_open_line();
            if (c.last_char) begin
                add_line(0, 0, 1'b1, 1'b0);
            end
        end else if (!c.glyph_found) begin
            add_line(0, 0, c.last_char, 1'b1);
            clear_open_line();
            skip_rest = !c.last_char;
        end else begin
            dx      = c.glyph_advance + ((c.char_code == CHAR_TAB) ? TAB_EXTRA : 0);
            tw      = c.last_char ? c.glyph_px : dx;
            again   = 1'b1;
            retried = 1'b0;
            while (again) begin
                again = 1'b0;
                if (line_w + tw > limit_w) begin
                    if (c.char_code == CHAR_SPACE) begin
                        // overflowing space closes the line right there
                        add_line(line_c, line_w, 1'b0, 1'b0);
                        clear_open_line();
                        if (c.last_char) begin
                            add_line(0, 0, 1'b1, 1'b0);
                        end
                    end else if (have_break && !retried) begin
                        // wrap at the last candidate, retry on the tail
                        add_line(brk_c, brk_w, 1'b0, 1'b0);
                        line_w     = tail_w;
                        line_c     = tail_c;
                        brk_w      = 0;
                        brk_c      = 0;
                        tail_w     = 0;
                        tail_c     = 0;
                        have_break = 1'b0;
                        retried    = 1'b1;
                        again      = 1'b1;
                    end else begin
                        // word does not fit anywhere
                        add_line(0, 0, c.last_char, 1'b1);
                        clear_open_line();
                        skip_rest = !c.last_char;
                    end
                end else begin
                    if (c.char_code == CHAR_SPACE) begin
                        brk_w      = line_w;
                        brk_c      = line_c;
                        have_break = 1'b1;
                        tail_w     = 0;
                        tail_c     = 0;
                        line_w     = line_w + dx;
                    end else if (c.char_code == CHAR_HYPHEN) begin
                        line_w     = line_w + dx;
                        brk_w      = (line_w > WIDTH_CAP) ? WIDTH_CAP : line_w;
                        brk_c      = line_c;
                        have_break = 1'b1;
                        tail_w     = 0;
                        tail_c     = 0;
                    end else begin
                        line_w = line_w + dx;
                        tail_w = (tail_w + dx > WIDTH_CAP) ? WIDTH_CAP : tail_w + dx;
                        tail_c = bump_count(tail_c);
                    end
                    line_c = bump_count(line_c);
                    if (c.last_char) begin
                        add_line(line_c, line_w, 1'b1, 1'b0);
                        clear_open_line();
                    end else if (line_w > WIDTH_CAP) begin
                        line_w = WIDTH_CAP;
                    end
                end
            end
        end
        if (staged_valid) begin
            staged.last_of_run = 1'b1;
            expected_lines.push_back(staged);
            staged_valid = 1'b0;
        end
    endtask

    // compare one popped line with the oldest prediction
    task automatic check_line(input t_line_result got);
        t_line_result want;
        o_lines_seen++;
        if (got.wrap_error) begin
            o_error_lines++;
        end
        if (expected_lines.size() == 0) begin
            $error("unexpected line: line_chars %0d line_px %0d",
                   got.line_chars, got.line_px);
            o_mismatches++;
        end else begin
            want = expected_lines.pop_front();
            if (got.line_chars !== want.line_chars) begin
                $error("line_chars: expected %0d, got %0d", want.line_chars, got.line_chars);
                o_mismatches++;
            end
            if (got.line_px !== want.line_px) begin
                $error("line_px: expected %0d, got %0d", want.line_px, got.line_px);
                o_mismatches++;
            end
            if (got.string_done !== want.string_done) begin
                $error("string_done: expected %0b, got %0b", want.string_done, got.string_done);
                o_mismatches++;
            end
            if (got.wrap_error !== want.wrap_error) begin
                $error("wrap_error: expected %0b, got %0b", want.wrap_error, got.wrap_error);
                o_mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
                o_mismatches++;
            end
        end
    endtask

    // sample the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_w = RESET_MAX_LINE_WIDTH;
            clear_open_line();
            skip_rest = 1'b0;
            expected_lines.delete();
        end else begin
            if (i_cfg_we) begin
                limit_w = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                predict_lines(i_char);
            end
            if (i_pop && !i_empty) begin
                check_line(i_line);
            end
        end
        o_lines_pending <= expected_lines.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the greedy word wrap line breaker
// directed strings for the break rules, then random text under a range of
// line widths with random gaps on the character side and random stalls on
// the line side; the checker predicts and compares every line
// ----------------------------------------------------------------------------
module tb;
    import gwb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         push        = 1'b0;
    logic         pop         = 1'b0;
    t_char_item   i_char      = '0;
    logic         i_cfg_we    = 1'b0;
    logic [11:0]  i_cfg_wdata = '0;
    logic         full;
    logic         empty;
    t_line_result o_line;

    int mismatches;
    int lines_pending;
    int lines_seen;
    int error_lines;

    // idling control: 0 means none, else a burst with a chance of one in that many
    int gap_odds    = 0;
    int stall_odds  = 0;
    int pop_hold    = 0;
    int cycles      = 0;
    int chars_sent  = 0;
    int widths_used = 0;
    int unsigned adv_hi = 10;

    greedy_word_wrap_line_breaker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char      (i_char),
        .empty       (empty),
        .pop         (pop),
        .o_line      (o_line),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    gwb_line_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_char          (i_char),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_line          (o_line),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_mismatches    (mismatches),
        .o_lines_pending (lines_pending),
        .o_lines_seen    (lines_seen),
        .o_error_lines   (error_lines)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // line side: pop with random stall bursts
    always @(posedge i_clk) begin
        if (pop_hold != 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            pop_hold <= $urandom_range(0, 8);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic t_char_item glyph(input logic [7:0] code, input logic [7:0] gw,
                                         input logic [7:0] adv);
        t_char_item it;
        it.char_code     = code;
        it.glyph_px      = gw;
        it.glyph_advance = adv;
        it.glyph_found   = 1'b1;
        it.last_char     = 1'b0;
        return it;
    endfunction

    // push one character, with an optional gap before it
    task automatic send_char(input t_char_item it, input logic last);
        it.last_char = last;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_char <= it;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        chars_sent++;
    endtask

    // write the width limit once all lines are out and the engine is quiet
    task automatic set_width(input logic [11:0] w);
        push <= 1'b0;
        @(posedge i_clk);
        while (lines_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_wdata <= w;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        widths_used++;
        adv_hi = (w / 8 > 255) ? 255 : ((w / 8 < 1) ? 1 : w / 8);
    endtask

    function automatic t_char_item rand_glyph(input logic [7:0] code);
        logic [7:0] adv;
        adv = 8'($urandom_range(0, adv_hi));
        return glyph(code, 8'($urandom_range(0, adv_hi)), adv);
    endfunction

    // one random string: words with separators, some noise and missing glyphs
    task automatic send_text(input int n_words);
        t_char_item text[$];
        t_char_item it;
        int         len;
        int         pick;
        if ($urandom_range(0, 9) == 0) begin
            text.push_back(rand_glyph(CHAR_SPACE));
        end
        for (int w = 0; w < n_words; w++) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 59);
                if (pick < 2) begin
                    it = glyph(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                    it.glyph_found = ($urandom_range(0, 7) != 0);
                end else if (pick == 2) begin
                    it = rand_glyph(8'($urandom_range(97, 122)));
                    it.glyph_found = 1'b0;
                end else begin
                    it = rand_glyph(8'($urandom_range(97, 122)));
                end
                text.push_back(it);
            end
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                text.push_back(rand_glyph(CHAR_SPACE));
            end else if (pick < 15) begin
                text.push_back(rand_glyph(CHAR_HYPHEN));
            end else if (pick < 17) begin
                text.push_back(rand_glyph(CHAR_NEWLINE));
            end else if (pick == 17) begin
                text.push_back(rand_glyph(CHAR_TAB));
            end else if (pick == 18) begin
                text.push_back(rand_glyph(CHAR_SPACE));
                text.push_back(rand_glyph(CHAR_SPACE));
            end
        end
        // a string may end on a word or on any separator
        if (text.size() > 1 && $urandom_range(0, 1) == 0) begin
            void'(text.pop_back());
        end
        foreach (text[i]) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    initial begin
        t_char_item  it;
        logic [11:0] w;
        int          goal;
        logic [11:0] fixed_w[6];

        fixed_w = '{12'd640, 12'd0, 12'd4095, 12'd1, 12'd60, 12'd300};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_odds   = 4;
        stall_odds = 4;

        // reset width: a short line, then newline inside and at the end
        send_char(glyph("a", 10, 10), 1'b0);
        send_char(glyph(CHAR_SPACE, 10, 10), 1'b0);
        send_char(glyph("b", 10, 10), 1'b1);
        send_char(glyph("x", 10, 10), 1'b0);
        send_char(glyph(CHAR_NEWLINE, 10, 10), 1'b0);
        send_char(glyph(CHAR_NEWLINE, 0, 0), 1'b1);

        set_width(12'd100);
        // wrap after a hyphen, the rest fits on the next line
        send_char(glyph("a", 30, 30), 1'b0);
        send_char(glyph("a", 30, 30), 1'b0);
        send_char(glyph(CHAR_HYPHEN, 20, 20), 1'b0);
        send_char(glyph("b", 30, 30), 1'b0);
        send_char(glyph("c", 5, 5), 1'b1);
        // tab extra, then a last space that overflows
        send_char(glyph(CHAR_TAB, 70, 70), 1'b0);
        send_char(glyph(CHAR_SPACE, 20, 20), 1'b1);
        // overflow again after a wrap, rest of the string dropped
        send_char(glyph("a", 10, 10), 1'b0);
        send_char(glyph(CHAR_SPACE, 10, 10), 1'b0);
        send_char(glyph("b", 200, 200), 1'b0);
        send_char(glyph(8'd0, 0, 0), 1'b1);
        // code zero, then a widest glyph with no candidate
        send_char(glyph(8'd0, 0, 0), 1'b0);
        send_char(glyph(8'd255, 255, 255), 1'b1);
        // missing glyph in the middle of a string
        send_char(glyph("a", 10, 10), 1'b0);
        it = glyph("m", 10, 10);
        it.glyph_found = 1'b0;
        send_char(it, 1'b0);
        send_char(glyph("b", 10, 10), 1'b1);

        // random text under several widths, extremes included
        goal = chars_sent;
        for (int p = 0; p < 9; p++) begin
            w = (p < 6) ? fixed_w[p] : 12'($urandom_range(0, 4095));
            set_width(w);
            gap_odds   = 3 * $urandom_range(0, 3);
            stall_odds = 3 * $urandom_range(0, 3);
            if (p == 2) begin
                // widest line: the line width saturates
                for (int k = 0; k < 16; k++) begin
                    send_char(glyph("w", 255, 255), 1'b0);
                end
                send_char(glyph("w", 10, 255), 1'b1);
                goal = chars_sent;
            end
            goal += 30;
            while (chars_sent < goal) send_text($urandom_range(1, 12));
        end

        // closing stretch with no idling on either side
        set_width(12'd180);
        gap_odds   = 0;
        stall_odds = 0;
        goal += 30;
        while (chars_sent < goal) send_text($urandom_range(1, 12));

        push <= 1'b0;
        @(posedge i_clk);
        while (lines_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d characters sent under %0d width settings", chars_sent, widths_used);
        $display("tb: %0d lines checked, %0d of them wrap errors", lines_seen, error_lines);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
